// File: rtl/hrhp_pkg.sv
// Shared types, codes and constants of the HTTP request header parser.
package hrhp_pkg;

  // Default width of the token length counter.
  localparam int LENGTH_WIDTH_DEFAULT = 12;

  // Width of one length limit register.
  localparam int MAX_WIDTH = 12;
  localparam int NUM_REGS  = 5;
  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_METHOD_MAX       = 3'd0;
  localparam logic [2:0] REG_PATH_MAX         = 3'd1;
  localparam logic [2:0] REG_VERSION_MAX      = 3'd2;
  localparam logic [2:0] REG_HEADER_NAME_MAX  = 3'd3;
  localparam logic [2:0] REG_HEADER_VALUE_MAX = 3'd4;

  // Reset values of the limits.
  localparam logic [MAX_WIDTH-1:0] METHOD_MAX_RESET       = 12'd7;
  localparam logic [MAX_WIDTH-1:0] PATH_MAX_RESET         = 12'd2048;
  localparam logic [MAX_WIDTH-1:0] VERSION_MAX_RESET      = 12'd8;
  localparam logic [MAX_WIDTH-1:0] HEADER_NAME_MAX_RESET  = 12'd64;
  localparam logic [MAX_WIDTH-1:0] HEADER_VALUE_MAX_RESET = 12'd1024;

  // Parser phases.
  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_PATH    = 4'd1;
  localparam logic [3:0] PH_VERSION = 4'd2;
  localparam logic [3:0] PH_RL_LF   = 4'd3;
  localparam logic [3:0] PH_NAME    = 4'd4;
  localparam logic [3:0] PH_VALUE   = 4'd5;
  localparam logic [3:0] PH_HDR_LF  = 4'd6;
  localparam logic [3:0] PH_END_LF  = 4'd7;

  // Token kinds.
  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_NAME    = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;
  localparam logic [2:0] KIND_DELIM   = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EMPTY      = 3'd1;
  localparam logic [2:0] ERR_MISSING_LF = 3'd7;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;

  // One input byte of the request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  // One classified byte.
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] token_kind;
    logic       token_start;
    logic       header_done;
    logic [2:0] error_code;
  } out_t;

  // Token length limits, indexed by token kind.
  typedef logic [NUM_REGS-1:0][MAX_WIDTH-1:0] cfg_max_t;

endpackage

// File: rtl/http_request_header_parser_unit.sv
// Top level of the HTTP request header parser: input and result registers.
// A request passes through the input register and then the result register.
// One byte per cycle unless the output stalls; parser state moves with each byte.
// Stalls on the output side hold the result register and then the input register.
// Reset (rst, synchronous): parser at start of request line, limits at defaults,
// both registers empty.
module http_request_header_parser_unit #(
  parameter int LENGTH_WIDTH = hrhp_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hrhp_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hrhp_pkg::out_t                   out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrhp_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [hrhp_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [hrhp_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready
);
  import hrhp_pkg::*;

  cfg_max_t cfg_max;
  in_t      in_reg;
  logic     in_reg_valid;
  out_t     result;
  logic     advance;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  hrhp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_max (cfg_max)
  );

  hrhp_classifier #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_classifier (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg_max (cfg_max),
    .result  (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/hrhp_cfg_regs.sv
// Configuration registers with an APB-style access port.
module hrhp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrhp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [hrhp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [hrhp_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready,
  output hrhp_pkg::cfg_max_t                cfg_max
);
  import hrhp_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max[REG_METHOD_MAX]       <= METHOD_MAX_RESET;
      cfg_max[REG_PATH_MAX]         <= PATH_MAX_RESET;
      cfg_max[REG_VERSION_MAX]      <= VERSION_MAX_RESET;
      cfg_max[REG_HEADER_NAME_MAX]  <= HEADER_NAME_MAX_RESET;
      cfg_max[REG_HEADER_VALUE_MAX] <= HEADER_VALUE_MAX_RESET;
    end else if (wr_en && (reg_index < 3'(NUM_REGS))) begin
      cfg_max[reg_index] <= pwdata[MAX_WIDTH-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (reg_index < 3'(NUM_REGS)) begin
      prdata = DATA_WIDTH'(cfg_max[reg_index]);
    end
  end

endmodule

// File: rtl/hrhp_classifier.sv
// Byte classifier: parser state and the logic that labels one byte.
module hrhp_classifier #(
  parameter int LENGTH_WIDTH = hrhp_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  hrhp_pkg::in_t       item,
  input  hrhp_pkg::cfg_max_t  cfg_max,
  output hrhp_pkg::out_t      result
);
  import hrhp_pkg::*;

  // Compare width covers both the counter and the limit registers.
  localparam int CW = (LENGTH_WIDTH > MAX_WIDTH) ? LENGTH_WIDTH : MAX_WIDTH;

  logic [3:0]              phase;
  logic [3:0]              phase_next;
  logic [LENGTH_WIDTH-1:0] token_length;
  logic [LENGTH_WIDTH-1:0] token_length_next;

  logic [3:0]              cur_phase;
  logic [LENGTH_WIDTH-1:0] cur_len;
  logic                    take;
  logic [2:0]              take_kind;
  logic [CW-1:0]           lim_raw;
  logic [CW-1:0]           len_mask;
  logic [CW-1:0]           lim;
  logic [7:0]              b;

  assign b        = item.data_byte;
  assign len_mask = CW'({LENGTH_WIDTH{1'b1}});

  // Classification of the byte in the input register.
  always_comb begin
    cur_phase         = item.restart ? PH_METHOD : phase;
    cur_len           = item.restart ? '0 : token_length;
    phase_next        = cur_phase;
    token_length_next = cur_len;
    take              = 1'b0;
    take_kind         = KIND_METHOD;
    result.byte_out    = b;
    result.token_kind  = KIND_DELIM;
    result.token_start = 1'b0;
    result.header_done = 1'b0;
    result.error_code  = ERR_NONE;

    unique case (cur_phase)
      PH_PATH: begin
        if (b == CH_SP) begin
          phase_next        = PH_VERSION;
          token_length_next = '0;
        end else begin
          take      = 1'b1;
          take_kind = KIND_PATH;
        end
      end
      PH_VERSION: begin
        if (b == CH_CR) begin
          phase_next        = PH_RL_LF;
          token_length_next = '0;
        end else begin
          take      = 1'b1;
          take_kind = KIND_VERSION;
        end
      end
      PH_RL_LF, PH_HDR_LF: begin
        if (b == CH_LF) begin
          phase_next = PH_NAME;
        end else begin
          result.error_code = ERR_MISSING_LF;
          phase_next        = PH_METHOD;
        end
        token_length_next = '0;
      end
      PH_NAME: begin
        if ((cur_len == '0) && (b == CH_CR)) begin
          phase_next        = PH_END_LF;
          token_length_next = '0;
        end else if (b == CH_COLON) begin
          phase_next        = PH_VALUE;
          token_length_next = '0;
        end else begin
          take      = 1'b1;
          take_kind = KIND_NAME;
        end
      end
      PH_VALUE: begin
        if (b == CH_CR) begin
          phase_next        = PH_HDR_LF;
          token_length_next = '0;
        end else if (!((cur_len == '0) && (b == CH_SP))) begin
          take      = 1'b1;
          take_kind = KIND_VALUE;
        end
      end
      PH_END_LF: begin
        if (b == CH_LF) begin
          result.header_done = 1'b1;
        end else begin
          result.error_code = ERR_MISSING_LF;
        end
        phase_next        = PH_METHOD;
        token_length_next = '0;
      end
      default: begin
        // Method phase; unused codes restart the request line.
        if (cur_phase != PH_METHOD) begin
          cur_len           = '0;
          phase_next        = PH_METHOD;
          token_length_next = '0;
        end
        if ((cur_len == '0) && (b == CH_NUL)) begin
          result.error_code = ERR_EMPTY;
          phase_next        = PH_METHOD;
          token_length_next = '0;
        end else if (b == CH_SP) begin
          phase_next        = PH_PATH;
          token_length_next = '0;
        end else begin
          take      = 1'b1;
          take_kind = KIND_METHOD;
        end
      end
    endcase

    // Limit of the token in hand, clamped to what the counter can hold.
    lim_raw = CW'(cfg_max[take_kind]);
    lim     = (lim_raw > len_mask) ? len_mask : lim_raw;

    // A token character: count it or flag the token as too long.
    if (take) begin
      result.token_kind  = take_kind;
      result.token_start = (cur_len == '0);
      if (CW'(cur_len) >= lim) begin
        result.error_code = take_kind + 3'd2;
        phase_next        = PH_METHOD;
        token_length_next = '0;
      end else begin
        token_length_next = cur_len + LENGTH_WIDTH'(1);
      end
    end
  end

  // Parser state moves on when the byte is handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_METHOD;
      token_length <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      token_length <= token_length_next;
    end
  end

endmodule

// File: bench/testbench.sv
// Testbench for the HTTP request header parser: predicts and checks every classified byte.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hrhp_pkg::*;

  localparam int LW = LENGTH_WIDTH_DEFAULT;
  // Too-long errors are numbered from this code upward, by token kind.
  localparam logic [2:0] ERR_TOO_LONG_BASE = 3'd2;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_LIMIT = 20000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  http_request_header_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Parser state as the testbench expects it.
  logic [3:0]           parse_phase;
  logic [LW-1:0]        parse_len;
  logic [MAX_WIDTH-1:0] token_limit [NUM_REGS];

  out_t predicted_bytes[$];
  in_t  request_bytes[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result for byte %02h", out_data.byte_out));
      end else begin
        want = predicted_bytes.pop_front();
        if (out_data.byte_out !== want.byte_out || out_data.token_kind !== want.token_kind ||
            out_data.token_start !== want.token_start ||
            out_data.header_done !== want.header_done ||
            out_data.error_code !== want.error_code) begin
          report_mismatch($sformatf(
            "mismatch: expected byte %02h kind %0d start %0d done %0d err %0d, got %02h %0d %0d %0d %0d",
            want.byte_out, want.token_kind, want.token_start, want.header_done,
            want.error_code, out_data.byte_out, out_data.token_kind, out_data.token_start,
            out_data.header_done, out_data.error_code));
        end
      end
    end
  end

  function automatic void reset_parser_model();
    parse_phase = PH_METHOD;
    parse_len = '0;
    token_limit[REG_METHOD_MAX] = METHOD_MAX_RESET;
    token_limit[REG_PATH_MAX] = PATH_MAX_RESET;
    token_limit[REG_VERSION_MAX] = VERSION_MAX_RESET;
    token_limit[REG_HEADER_NAME_MAX] = HEADER_NAME_MAX_RESET;
    token_limit[REG_HEADER_VALUE_MAX] = HEADER_VALUE_MAX_RESET;
  endfunction

  function automatic void goto_phase(logic [3:0] next_phase);
    parse_phase = next_phase;
    parse_len = '0;
  endfunction

  // Count one token character against its limit; returns the error it raises.
  function automatic logic [2:0] take_token_char(logic [2:0] kind, inout out_t r);
    int lim;
    lim = token_limit[kind];
    if (lim > (1 << LW) - 1) lim = (1 << LW) - 1;
    r.token_kind = kind;
    r.token_start = (parse_len == 0);
    if (int'(parse_len) >= lim) begin
      goto_phase(PH_METHOD);
      return ERR_TOO_LONG_BASE + kind;
    end
    parse_len = parse_len + 1'b1;
    return ERR_NONE;
  endfunction

  // Classify one byte and advance the expected parser state.
  function automatic out_t classify_byte(in_t item);
    out_t       r;
    logic [7:0] b;
    logic [2:0] err;
    b = item.data_byte;
    err = ERR_NONE;
    r.byte_out = b;
    r.token_kind = KIND_DELIM;
    r.token_start = 1'b0;
    r.header_done = 1'b0;
    if (item.restart) goto_phase(PH_METHOD);
    case (parse_phase)
      PH_PATH: begin
        if (b == CH_SP) goto_phase(PH_VERSION);
        else err = take_token_char(KIND_PATH, r);
      end
      PH_VERSION: begin
        if (b == CH_CR) goto_phase(PH_RL_LF);
        else err = take_token_char(KIND_VERSION, r);
      end
      PH_RL_LF, PH_HDR_LF: begin
        if (b == CH_LF) goto_phase(PH_NAME);
        else begin
          err = ERR_MISSING_LF;
          goto_phase(PH_METHOD);
        end
      end
      PH_NAME: begin
        if (parse_len == 0 && b == CH_CR) goto_phase(PH_END_LF);
        else if (b == CH_COLON) goto_phase(PH_VALUE);
        else err = take_token_char(KIND_NAME, r);
      end
      PH_VALUE: begin
        // Leading spaces of a value are skipped.
        if (b == CH_CR) goto_phase(PH_HDR_LF);
        else if (!(parse_len == 0 && b == CH_SP)) err = take_token_char(KIND_VALUE, r);
      end
      PH_END_LF: begin
        if (b == CH_LF) r.header_done = 1'b1;
        else err = ERR_MISSING_LF;
        goto_phase(PH_METHOD);
      end
      default: begin
        // Unused phase codes behave like the start of a request.
        if (parse_phase != PH_METHOD) goto_phase(PH_METHOD);
        if (parse_len == 0 && b == CH_NUL) begin
          err = ERR_EMPTY;
          goto_phase(PH_METHOD);
        end else if (b == CH_SP) begin
          goto_phase(PH_PATH);
        end else begin
          err = take_token_char(KIND_METHOD, r);
        end
      end
    endcase
    if (err != ERR_NONE && r.token_kind == KIND_DELIM) r.token_start = 1'b0;
    r.error_code = err;
    return r;
  endfunction

  // Write one limit register with junk in the upper bits, then read it back if the index is in range.
  task automatic write_limit(input int idx, input logic [MAX_WIDTH-1:0] value);
    logic [DATA_WIDTH-1:0] word;
    word = $urandom();
    word[MAX_WIDTH-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_WIDTH'(idx * 4);
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    if (idx < NUM_REGS) begin
      token_limit[idx] = value;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== DATA_WIDTH'(value))
        report_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata, value));
      penable <= 1'b0;
    end
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [MAX_WIDTH-1:0] m, p, v, n, val);
    write_limit(REG_METHOD_MAX, m);
    write_limit(REG_PATH_MAX, p);
    write_limit(REG_VERSION_MAX, v);
    write_limit(REG_HEADER_NAME_MAX, n);
    write_limit(REG_HEADER_VALUE_MAX, val);
  endtask

  // Offer one byte, idling first at random, and wait until the request is accepted.
  task automatic send_byte(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predicted_bytes.push_back(classify_byte(item));
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(in_t'{data_byte: s[i], restart: 1'b0});
  endtask

  // Stop offering bytes and let every predicted result come out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (predicted_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == c);
    return v;
  endfunction

  // Token length of at most one past its limit, capped at ten, so that some tokens run over.
  function automatic int pick_len(int lim);
    return $urandom_range(0, (lim > 9) ? 10 : lim + 1);
  endfunction

  function automatic void push_char(logic [7:0] b);
    request_bytes.push_back(in_t'{data_byte: b, restart: 1'b0});
  endfunction

  // Queue one request: mostly well formed, some corrupted or cut short, some noise.
  function automatic void build_request();
    int first, sel, n, h, i, j;
    first = request_bytes.size();
    sel = $urandom_range(99);
    if (sel < 10) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
        request_bytes.push_back(in_t'{data_byte: 8'($urandom_range(255)),
                                      restart: ($urandom_range(7) == 0)});
    end else begin
      n = pick_len(token_limit[KIND_METHOD]);
      for (i = 0; i < n; i++) push_char(byte_except(CH_SP, CH_NUL));
      push_char(CH_SP);
      n = pick_len(token_limit[KIND_PATH]);
      for (i = 0; i < n; i++) push_char(byte_except(CH_SP, CH_SP));
      push_char(CH_SP);
      n = pick_len(token_limit[KIND_VERSION]);
      for (i = 0; i < n; i++) push_char(byte_except(CH_CR, CH_CR));
      push_char(CH_CR);
      push_char(CH_LF);
      h = $urandom_range(0, 3);
      for (j = 0; j < h; j++) begin
        n = pick_len(token_limit[KIND_NAME]);
        for (i = 0; i < n; i++)
          push_char(i == 0 ? byte_except(CH_CR, CH_COLON) : byte_except(CH_COLON, CH_COLON));
        push_char(CH_COLON);
        repeat ($urandom_range(0, 2)) push_char(CH_SP);
        n = pick_len(token_limit[KIND_VALUE]);
        for (i = 0; i < n; i++)
          push_char(i == 0 ? byte_except(CH_CR, CH_SP) : byte_except(CH_CR, CH_CR));
        push_char(CH_CR);
        push_char(CH_LF);
      end
      push_char(CH_CR);
      push_char(CH_LF);
      // Break some requests by overwriting one byte or cutting the tail off.
      if (sel < 25) begin
        i = $urandom_range(first, request_bytes.size() - 1);
        if (sel < 18) request_bytes[i].data_byte = 8'($urandom_range(255));
        else while (request_bytes.size() > i) void'(request_bytes.pop_back());
      end
    end
    if (request_bytes.size() > first && $urandom_range(3) == 0)
      request_bytes[first].restart = 1'b1;
  endfunction

  task automatic run_requests(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if (request_bytes.size() == 0) build_request();
      send_byte(request_bytes.pop_front());
      sent++;
    end
    request_bytes.delete();
  endtask

  // Hand-picked bytes for most errors and for corners of the grammar.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(12'd3, 12'd4095, 12'd0, 12'd1, 12'd4095);
    // Writes past the last register must change nothing.
    write_limit(NUM_REGS, 12'h001);
    write_limit(NUM_REGS + 2, 12'hFFF);
    send_byte(in_t'{data_byte: CH_NUL, restart: 1'b0});
    send_text("GETT");
    // Empty method and version, then an empty header section.
    send_text(" / \015\012\015\012");
    // Name longer than one character.
    send_text(" x \015\012ab");
    // A restart in the middle of a method, then a byte where LF is due.
    send_text("Q");
    send_byte(in_t'{data_byte: 8'hFF, restart: 1'b1});
    send_text(" \015 \015X");
    // Version limit of zero rejects its first character.
    send_text("  V");
    wait_drained();
  endtask

  task automatic test_requests_slow_receiver();
    set_limits(12'd7, 12'd12, 12'd8, 12'd6, 12'd10);
    send_idle_pct = 33;
    recv_idle_pct = 87;
    run_requests(170);
    wait_drained();
  endtask

  task automatic test_requests_slow_sender();
    set_limits(12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    send_idle_pct = 87;
    recv_idle_pct = 33;
    run_requests(170);
    wait_drained();
  endtask

  task automatic test_requests_full_rate();
    set_limits(12'($urandom_range(0, 16)), 12'($urandom_range(0, 16)),
               12'($urandom_range(0, 16)), 12'($urandom_range(0, 16)),
               12'($urandom_range(0, 16)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_requests(170);
    wait_drained();
  endtask

  // Hold the result side off long enough that the block stops taking bytes.
  task automatic test_input_backpressure();
    set_limits(METHOD_MAX_RESET, PATH_MAX_RESET, VERSION_MAX_RESET,
               HEADER_NAME_MAX_RESET, HEADER_VALUE_MAX_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    run_requests(40);
    wait_drained();
  endtask

  // Reset once, run every test, then report.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_parser_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_requests_slow_receiver();
    test_requests_slow_sender();
    test_requests_full_rate();
    test_input_backpressure();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: http_request_header_parser_unit.f
rtl/hrhp_pkg.sv
rtl/hrhp_cfg_regs.sv
rtl/hrhp_classifier.sv
rtl/http_request_header_parser_unit.sv
bench/testbench.sv
